// File: rtl/brfifo_pkg.sv
// Shared types and codes for the byte ring FIFO with delimiter scan.
`timescale 1ns / 1ps
package brfifo_pkg;

  // Request kinds carried in s_tuser
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Ring size after reset
  localparam int RING_SIZE_RESET = 1024;
  localparam int RING_SIZE_W     = 11;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_RD_REQ  = 4'b0010,
    S_RD_WAIT = 4'b0100,
    S_FIND    = 4'b1000
  } state_t;

  // One result item
  typedef struct packed {
    logic [7:0] data_out;
    logic       accepted;
    logic [9:0] position;
    logic [9:0] fill_count;
    logic [9:0] vacancy;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

// File: rtl/brfifo_ram.sv
// Byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module brfifo_ram #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/brfifo_level.sv
// Fill count and free space of the ring from head, tail and ring size.
`timescale 1ns / 1ps
module brfifo_level #(
  parameter int IW = 10,
  parameter int SW = 11
) (
  input  logic [IW-1:0] widx,
  input  logic [IW-1:0] ridx,
  input  logic [SW-1:0] size,
  output logic [IW-1:0] fill,
  output logic [IW-1:0] free
);

  logic [SW-1:0] w;
  logic [SW-1:0] r;
  logic [SW-1:0] diff;

  // head behind tail means the data wraps past the end of the ring
  always_comb begin
    w    = SW'(widx);
    r    = SW'(ridx);
    diff = (w >= r) ? (w - r) : (size - r + w);
    fill = IW'(diff);
    free = IW'(size - SW'(1) - diff);
  end

endmodule

// File: rtl/byte_ring_fifo_with_delimiter_scan.sv
// Top level: request sequencer, ring indices, burst tracking and result register.
`timescale 1ns / 1ps
// Byte ring FIFO with all-or-nothing write bursts and a byte search.
// Requests enter on the s_ stream (kind and burst start in s_tuser, byte and
// length in s_tdata); results leave on the m_ stream, m_tlast on the final
// result of each request. cfg_wen/cfg_wdata set the ring size, which also
// empties the ring; write it only while the block is idle.
// Writes, clears and reads that return nothing give their result in the cycle
// after they are accepted and can be accepted back to back while m_tready is high.
// A read returns its bytes one at a time: it addresses the store, then moves the
// store's registered read data into the result register once that is free, and
// only then addresses the next byte; no new request is taken until the last byte.
// A find compares one stored byte per cycle through the store's read port and
// gives its result on the first hit, or once every stored byte is compared; the
// next request can follow once that result is loaded.
// Reset empties the ring, cancels any burst and sets the ring size to 1024
// (or DEPTH if smaller); the store itself is not cleared, no clearing pass.
// A single result register sits on the output; while the receiver stalls it
// holds its item and no new request is taken.
module byte_ring_fifo_with_delimiter_scan #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], req_len[17:8], zero pad
  input  logic [2:0]  s_tuser,   // req_type[1:0], burst_first[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_out[7:0], position[17:8], fill_count[27:18],
                                 // vacancy[37:28], zero pad
  output logic [2:0]  m_tuser,   // accepted[0], status[2:1]
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > brfifo_pkg::RING_SIZE_W) ? SW : brfifo_pkg::RING_SIZE_W;
  localparam int NW = $clog2(MAX_READ + 1);
  localparam int EFF_RESET =
    (DEPTH < brfifo_pkg::RING_SIZE_RESET) ? DEPTH : brfifo_pkg::RING_SIZE_RESET;

  // next index around the ring
  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] i,
                                             input logic [SW-1:0] s);
    return (SW'(i) == (s - SW'(1))) ? '0 : (i + IW'(1));
  endfunction

  // request fields
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       burst_first;
  logic [9:0] req_len;

  assign req_type    = s_tuser[1:0];
  assign burst_first = s_tuser[2];
  assign data_byte   = s_tdata[7:0];
  assign req_len     = s_tdata[17:8];

  // registers
  brfifo_pkg::state_t  state, state_next;
  logic [IW-1:0]       widx, widx_next;
  logic [IW-1:0]       ridx, ridx_next;
  logic [SW-1:0]       eff_size;
  logic                burst_acc, burst_acc_next;
  logic [9:0]          burst_left, burst_left_next;
  logic [NW-1:0]       rd_left, rd_left_next;
  logic [7:0]          target;
  logic [IW-1:0]       scan_addr, scan_addr_next;
  logic [IW-1:0]       scan_cnt, scan_cnt_next;
  logic                cmp_valid, cmp_valid_next;
  logic [IW-1:0]       cmp_pos, cmp_pos_next;
  logic                out_valid;
  brfifo_pkg::result_t out_res, res_next, res_load;

  // control
  logic          out_free;
  logic          s_accept;
  logic          load;
  logic          wr_en;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [IW-1:0] cur_fill, cur_free;
  logic [IW-1:0] nx_fill, nx_free;
  logic          acc_now, store;
  logic [9:0]    left_now;
  logic [CW-1:0] len_w, fill_w, min_lc, rd_n;
  logic          step, match;
  logic [CW-1:0] cfg_w;
  logic [SW-1:0] cfg_eff;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == brfifo_pkg::S_IDLE) && out_free;
  assign s_accept = s_tvalid && s_tready;

  // byte store
  brfifo_ram #(.DEPTH(DEPTH), .IW(IW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (widx),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // level of the ring now and after this cycle
  brfifo_level #(.IW(IW), .SW(SW)) u_lvl_cur (
    .widx (widx),
    .ridx (ridx),
    .size (eff_size),
    .fill (cur_fill),
    .free (cur_free)
  );

  brfifo_level #(.IW(IW), .SW(SW)) u_lvl_nx (
    .widx (widx_next),
    .ridx (ridx_next),
    .size (eff_size),
    .fill (nx_fill),
    .free (nx_free)
  );

  // ring size clamped to [2, DEPTH]
  always_comb begin
    cfg_w = CW'(cfg_wdata);
    if (cfg_w < CW'(2)) begin
      cfg_eff = SW'(2);
    end else if (cfg_w > CW'(DEPTH)) begin
      cfg_eff = SW'(DEPTH);
    end else begin
      cfg_eff = SW'(cfg_w);
    end
  end

  // burst admission and read length
  always_comb begin
    len_w    = CW'(req_len);
    fill_w   = CW'(cur_fill);
    acc_now  = burst_first ? ((req_len != 10'd0) && (len_w <= CW'(cur_free))) : burst_acc;
    left_now = burst_first ? (acc_now ? req_len : 10'd0) : burst_left;
    store    = acc_now && (left_now != 10'd0) && (cur_free != '0);
    min_lc   = (len_w < fill_w) ? len_w : fill_w;
    rd_n     = (min_lc < CW'(MAX_READ)) ? min_lc : CW'(MAX_READ);
    step     = out_free;
    match    = cmp_valid && (rd_data == target);
  end

  // sequencer
  always_comb begin
    state_next      = state;
    widx_next       = widx;
    ridx_next       = ridx;
    burst_acc_next  = burst_acc;
    burst_left_next = burst_left;
    rd_left_next    = rd_left;
    scan_addr_next  = scan_addr;
    scan_cnt_next   = scan_cnt;
    cmp_valid_next  = cmp_valid;
    cmp_pos_next    = cmp_pos;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = ridx;
    load            = 1'b0;
    res_next        = '0;
    res_next.last   = 1'b1;

    unique case (state)
      brfifo_pkg::S_IDLE: begin
        if (s_accept) begin
          unique case (req_type)
            brfifo_pkg::REQ_WRITE: begin
              load = 1'b1;
              if (store) begin
                wr_en             = 1'b1;
                widx_next         = inc_wrap(widx, eff_size);
                burst_left_next   = left_now - 10'd1;
                burst_acc_next    = (left_now != 10'd1);
                res_next.accepted = 1'b1;
                res_next.status   = brfifo_pkg::ST_OK;
              end else begin
                burst_acc_next  = acc_now;
                burst_left_next = left_now;
                res_next.status = brfifo_pkg::ST_DROPPED;
              end
            end
            brfifo_pkg::REQ_READ: begin
              if (rd_n == '0) begin
                load            = 1'b1;
                res_next.status = brfifo_pkg::ST_EMPTY;
              end else begin
                rd_left_next = NW'(rd_n);
                state_next   = brfifo_pkg::S_RD_REQ;
              end
            end
            brfifo_pkg::REQ_FIND: begin
              scan_addr_next = ridx;
              scan_cnt_next  = '0;
              cmp_valid_next = 1'b0;
              state_next     = brfifo_pkg::S_FIND;
            end
            brfifo_pkg::REQ_CLEAR: begin
              load            = 1'b1;
              widx_next       = '0;
              ridx_next       = '0;
              burst_acc_next  = 1'b0;
              burst_left_next = 10'd0;
              res_next.status = brfifo_pkg::ST_OK;
            end
          endcase
        end
      end

      // address the oldest byte
      brfifo_pkg::S_RD_REQ: begin
        rd_en      = 1'b1;
        rd_addr    = ridx;
        state_next = brfifo_pkg::S_RD_WAIT;
      end

      // hand the byte over once the result register is free
      brfifo_pkg::S_RD_WAIT: begin
        if (out_free) begin
          load              = 1'b1;
          ridx_next         = inc_wrap(ridx, eff_size);
          rd_left_next      = rd_left - NW'(1);
          res_next.data_out = rd_data;
          res_next.accepted = 1'b1;
          res_next.status   = brfifo_pkg::ST_OK;
          res_next.last     = (rd_left == NW'(1));
          state_next        = (rd_left == NW'(1)) ? brfifo_pkg::S_IDLE
                                                  : brfifo_pkg::S_RD_REQ;
        end
      end

      // one read issued and one compare done per cycle
      brfifo_pkg::S_FIND: begin
        rd_addr = scan_addr;
        if (step) begin
          rd_en          = (scan_cnt != cur_fill);
          cmp_valid_next = rd_en;
          cmp_pos_next   = scan_cnt;
          if (rd_en) begin
            scan_addr_next = inc_wrap(scan_addr, eff_size);
            scan_cnt_next  = scan_cnt + IW'(1);
          end
          if (match) begin
            rd_en             = 1'b0;
            cmp_valid_next    = 1'b0;
            load              = 1'b1;
            res_next.position = 10'(cmp_pos + IW'(1));
            res_next.status   = brfifo_pkg::ST_OK;
            state_next        = brfifo_pkg::S_IDLE;
          end else if (scan_cnt == cur_fill) begin
            load            = 1'b1;
            res_next.status = brfifo_pkg::ST_NOT_FOUND;
            state_next      = brfifo_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = brfifo_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= brfifo_pkg::S_IDLE;
      widx       <= '0;
      ridx       <= '0;
      eff_size   <= SW'(EFF_RESET);
      burst_acc  <= 1'b0;
      burst_left <= 10'd0;
      rd_left    <= '0;
      cmp_valid  <= 1'b0;
    end else if (cfg_wen) begin
      eff_size   <= cfg_eff;
      widx       <= '0;
      ridx       <= '0;
      burst_acc  <= 1'b0;
      burst_left <= 10'd0;
    end else begin
      state      <= state_next;
      widx       <= widx_next;
      ridx       <= ridx_next;
      burst_acc  <= burst_acc_next;
      burst_left <= burst_left_next;
      rd_left    <= rd_left_next;
      cmp_valid  <= cmp_valid_next;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    scan_cnt  <= scan_cnt_next;
    cmp_pos   <= cmp_pos_next;
    if (s_accept) begin
      target <= data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result with the ring level after this cycle
  always_comb begin
    res_load            = res_next;
    res_load.fill_count = 10'(nx_fill);
    res_load.vacancy    = 10'(nx_free);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_load;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.vacancy, out_res.fill_count,
                     out_res.position, out_res.data_out};
  assign m_tuser  = {out_res.status, out_res.accepted};
  assign m_tlast  = out_res.last;

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten while stalled");

  // indices stay inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (SW'(widx) < eff_size) && (SW'(ridx) < eff_size))
    else $error("ring index beyond ring size");

  // the store is written only by an accepted write request
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s_accept && (req_type == brfifo_pkg::REQ_WRITE)))
    else $error("store written outside a write request");

  // reads and writes of the store never overlap in time
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (!wr_en && (state != brfifo_pkg::S_IDLE)))
    else $error("store read while idle or during a write");

  // a read burst ends with a result marked last
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    (state == brfifo_pkg::S_RD_WAIT && load && rd_left == NW'(1)) |=>
      (m_tvalid && m_tlast))
    else $error("read burst ended without last");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the byte ring FIFO with delimiter scan.
`timescale 1ns / 1ps
module testbench;

  localparam int RING_DEPTH = 1024;
  localparam int READ_CAP   = 64;

  // One request item as the sender sees it
  typedef struct {
    logic [1:0] kind;
    logic [7:0] val;
    logic       burst_first;
    logic [9:0] len;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // data_byte[7:0], req_len[17:8], zero pad
  logic [2:0]  s_tuser = '0;   // req_type[1:0], burst_first[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // data_out, position, fill_count, vacancy, zero pad
  logic [2:0]  m_tuser;        // accepted[0], status[2:1]
  logic        m_tlast;
  logic        cfg_wen = 1'b0;
  logic [10:0] cfg_wdata = '0;

  byte_ring_fifo_with_delimiter_scan #(
    .DEPTH    (RING_DEPTH),
    .MAX_READ (READ_CAP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stimulus and expected results
  req_t                pending_reqs[$];
  brfifo_pkg::result_t due_results[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Shadow of the ring
  logic [7:0]  ring_mem [0:RING_DEPTH-1];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned burst_left = 0;
  bit          burst_open = 1'b0;
  int unsigned ring_reg = brfifo_pkg::RING_SIZE_RESET;

  // Run statistics
  int unsigned n_reqs = 0;
  int unsigned n_results = 0;
  int unsigned n_read_bytes = 0;
  int unsigned n_find_hits = 0;
  int unsigned n_dropped = 0;
  int unsigned errors = 0;

  // Slots in use: register held within [2, depth]
  function automatic int unsigned ring_slots();
    int unsigned s;
    s = ring_reg;
    if (s < 2) s = 2;
    if (s > RING_DEPTH) s = RING_DEPTH;
    return s;
  endfunction

  function automatic int unsigned held();
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return ring_slots() - rd_ptr + wr_ptr;
  endfunction

  function automatic int unsigned room();
    int unsigned c;
    c = held();
    return (c + 1 <= ring_slots()) ? ring_slots() - c - 1 : 0;
  endfunction

  // Queue one result; counts are taken after the pointer update
  function automatic void expect_result(input logic [7:0] d, input logic acc,
                                        input int unsigned pos, input logic [1:0] st,
                                        input logic lst);
    brfifo_pkg::result_t r;
    r.data_out   = d;
    r.accepted   = acc;
    r.position   = 10'(pos);
    r.fill_count = 10'(held());
    r.vacancy    = 10'(room());
    r.status     = st;
    r.last       = lst;
    due_results.push_back(r);
  endfunction

  // Work out every result that one accepted request causes
  function automatic void ring_apply(input req_t q);
    int unsigned n;
    int unsigned i;
    logic [7:0]  b;
    bit          hit;
    case (q.kind)
      brfifo_pkg::REQ_WRITE: begin
        if (q.burst_first) begin
          burst_open = (q.len >= 1 && q.len <= room());
          burst_left = burst_open ? q.len : 0;
        end
        if (burst_open && burst_left > 0 && room() > 0) begin
          ring_mem[wr_ptr] = q.val;
          wr_ptr = (wr_ptr + 1) % ring_slots();
          burst_left--;
          if (burst_left == 0) burst_open = 1'b0;
          expect_result(8'h00, 1'b1, 0, brfifo_pkg::ST_OK, 1'b1);
        end else begin
          n_dropped++;
          expect_result(8'h00, 1'b0, 0, brfifo_pkg::ST_DROPPED, 1'b1);
        end
      end
      brfifo_pkg::REQ_READ: begin
        n = q.len;
        if (n > held()) n = held();
        if (n > READ_CAP) n = READ_CAP;
        if (n == 0) expect_result(8'h00, 1'b0, 0, brfifo_pkg::ST_EMPTY, 1'b1);
        for (i = 0; i < n; i++) begin
          b = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % ring_slots();
          n_read_bytes++;
          expect_result(b, 1'b1, 0, brfifo_pkg::ST_OK, i + 1 == n);
        end
      end
      brfifo_pkg::REQ_FIND: begin
        n = held();
        hit = 1'b0;
        for (i = 0; i < n && !hit; i++) begin
          if (ring_mem[(rd_ptr + i) % ring_slots()] == q.val) begin
            hit = 1'b1;
            expect_result(8'h00, 1'b0, i + 1, brfifo_pkg::ST_OK, 1'b1);
          end
        end
        if (hit) n_find_hits++;
        else expect_result(8'h00, 1'b0, 0, brfifo_pkg::ST_NOT_FOUND, 1'b1);
      end
      default: begin
        wr_ptr = 0;
        rd_ptr = 0;
        burst_open = 1'b0;
        burst_left = 0;
        expect_result(8'h00, 1'b0, 0, brfifo_pkg::ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Sender: one item held on the bus until taken
  always @(posedge clk) begin
    req_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        cur.kind        = s_tuser[1:0];
        cur.burst_first = s_tuser[2];
        cur.val         = s_tdata[7:0];
        cur.len         = s_tdata[17:8];
        n_reqs++;
        ring_apply(cur);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, cur.len, cur.val};
          s_tuser  <= {cur.burst_first, cur.kind};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    brfifo_pkg::result_t got;
    brfifo_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      got.data_out   = m_tdata[7:0];
      got.position   = m_tdata[17:8];
      got.fill_count = m_tdata[27:18];
      got.vacancy    = m_tdata[37:28];
      got.accepted   = m_tuser[0];
      got.status     = m_tuser[2:1];
      got.last       = m_tlast;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none due: data %h acc %b pos %0d fill %0d %s",
                   $realtime, got.data_out, got.accepted, got.position, got.fill_count,
                   $sformatf("free %0d st %0d last %b",
                             got.vacancy, got.status, got.last));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch on result %0d", $realtime, n_results);
            $display("  expected data %h acc %b pos %0d fill %0d free %0d st %0d last %b",
                     want.data_out, want.accepted, want.position, want.fill_count,
                     want.vacancy, want.status, want.last);
            $display("  actual   data %h acc %b pos %0d fill %0d free %0d st %0d last %b",
                     got.data_out, got.accepted, got.position, got.fill_count,
                     got.vacancy, got.status, got.last);
          end
        end
      end
    end
  end

  function automatic void add_req(input logic [1:0] kind, input logic [7:0] val,
                                  input logic first, input logic [9:0] len);
    req_t q;
    q.kind = kind;
    q.val = val;
    q.burst_first = first;
    q.len = len;
    pending_reqs.push_back(q);
  endfunction

  // Mostly a small alphabet so that finds hit
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 70) return 8'($urandom_range(5));
    return 8'($urandom_range(255));
  endfunction

  // Random mix: mostly well-formed bursts, plus reads, finds, clears and noise
  function automatic void gen_mix(input int unsigned count);
    int unsigned made;
    int unsigned r;
    int unsigned l;
    int unsigned k;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        l = $urandom_range(1, 6);
        for (k = 0; k < l; k++)
          add_req(brfifo_pkg::REQ_WRITE, pick_byte(), k == 0,
                  (k == 0) ? 10'(l) : 10'($urandom_range(1023)));
        made += l;
      end else if (r < 57) begin
        // broken bursts: zero length, random length, stray byte, overrun
        case ($urandom_range(3))
          0: begin
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b1, 10'd0);
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b0, 10'($urandom_range(1023)));
            made += 2;
          end
          1: begin
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b1, 10'($urandom_range(1023)));
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b0, 10'($urandom_range(1023)));
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b0, 10'($urandom_range(1023)));
            made += 3;
          end
          2: begin
            add_req(brfifo_pkg::REQ_WRITE, pick_byte(), 1'b0, 10'($urandom_range(1023)));
            made += 1;
          end
          default: begin
            l = $urandom_range(1, 3);
            for (k = 0; k < l + 2; k++)
              add_req(brfifo_pkg::REQ_WRITE, pick_byte(), k == 0, 10'(l));
            made += l + 2;
          end
        endcase
      end else if (r < 77) begin
        add_req(brfifo_pkg::REQ_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                ($urandom_range(99) < 70) ? 10'($urandom_range(8))
                                          : 10'($urandom_range(1023)));
        made += 1;
      end else if (r < 94) begin
        add_req(brfifo_pkg::REQ_FIND, pick_byte(), 1'($urandom_range(1)),
                10'($urandom_range(1023)));
        made += 1;
      end else begin
        add_req(brfifo_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                10'($urandom_range(1023)));
        made += 1;
      end
    end
  endfunction

  // Settled once every item is taken and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // New ring size while idle, then a random phase
  task automatic run_phase(input logic [10:0] size, input int unsigned idle,
                           input int unsigned stall, input int unsigned count,
                           input bit long_read);
    int unsigned k;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wdata <= size;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    ring_reg   = size;
    wr_ptr     = 0;
    rd_ptr     = 0;
    burst_open = 1'b0;
    burst_left = 0;
    idle_pct   = idle;
    stall_pct  = stall;
    // fill past the read cap, then read back in one request that the cap cuts short
    if (long_read) begin
      for (k = 0; k < 70; k++)
        add_req(brfifo_pkg::REQ_WRITE, 8'($urandom_range(255)), k == 0, 10'd70);
      add_req(brfifo_pkg::REQ_READ, 8'h00, 1'b0, 10'd1023);
    end
    gen_mix(count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring, stray and zero-length writes, extremes
    add_req(brfifo_pkg::REQ_READ,  8'h00, 1'b0, 10'd5);
    add_req(brfifo_pkg::REQ_FIND,  8'h00, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_WRITE, 8'hAA, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_WRITE, 8'h55, 1'b1, 10'd0);
    add_req(brfifo_pkg::REQ_WRITE, 8'h00, 1'b1, 10'd3);
    add_req(brfifo_pkg::REQ_WRITE, 8'hFF, 1'b0, 10'd1023);
    add_req(brfifo_pkg::REQ_WRITE, 8'h41, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_WRITE, 8'h42, 1'b0, 10'd0);   // past the declared length
    add_req(brfifo_pkg::REQ_FIND,  8'h41, 1'b1, 10'd1023);
    add_req(brfifo_pkg::REQ_FIND,  8'hFF, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_FIND,  8'h99, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_READ,  8'hFF, 1'b1, 10'd0);
    add_req(brfifo_pkg::REQ_READ,  8'h00, 1'b0, 10'd1023);
    add_req(brfifo_pkg::REQ_WRITE, 8'h80, 1'b1, 10'd1023); // exactly fits an empty ring
    add_req(brfifo_pkg::REQ_WRITE, 8'h7F, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_WRITE, 8'h01, 1'b1, 10'd1022); // one more than free
    add_req(brfifo_pkg::REQ_WRITE, 8'h02, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_FIND,  8'h7F, 1'b0, 10'd0);
    add_req(brfifo_pkg::REQ_CLEAR, 8'hFF, 1'b1, 10'd1023);
    add_req(brfifo_pkg::REQ_READ,  8'h00, 1'b0, 10'd1);
    add_req(brfifo_pkg::REQ_FIND,  8'h80, 1'b0, 10'd0);

    run_phase(11'd2047, 0,  0,  55, 1'b0);
    run_phase(11'd7,    73, 0,  50, 1'b0);
    run_phase(11'd2,    0,  73, 40, 1'b0);
    run_phase(11'd1,    34, 34, 25, 1'b0);
    run_phase(11'd1024, 0,  73, 10, 1'b1);
    run_phase(11'd37,   34, 34, 40, 1'b0);
    run_phase(11'd0,    73, 0,  20, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d results over ring sizes 0, 1, 2, 7, 37, 1024, 2047",
             n_reqs, n_results);
    $display("with %0d bytes read, %0d find hits, %0d dropped writes, idle and stall up to 73%%",
             n_read_bytes, n_find_hits, n_dropped);
    if (errors == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Timed out with %0d results still due", due_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
